### rtl/core/mctb_pkg.sv
// Shared types and constants for the multi-channel timeout bank.
package mctb_pkg;

    // Widest bank that the channel field can address.
    localparam int MAX_CHANNELS = 8;
    localparam int CHAN_W       = 3;
    localparam int COUNT_W      = 16;
    localparam int FLAGS_W      = 8;

    localparam int CHANNELS_DEFAULT = 8;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_TEST  = 2'd3
    } cmd_code_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [CHAN_W-1:0]  channel;
        logic [COUNT_W-1:0] reload_period;
        logic [COUNT_W-1:0] first_delay;
    } cmd_t;

    typedef struct packed {
        logic               was_expired;
        logic [FLAGS_W-1:0] active_bits;
        logic [FLAGS_W-1:0] expired_bits;
    } rsp_t;

    // Controller to datapath.
    typedef struct packed {
        logic              load;
        logic              apply;
        logic              rd_en;
        logic [CHAN_W-1:0] rd_idx;
        logic              upd_en;
        logic [CHAN_W-1:0] upd_idx;
        logic              capture;
    } ctl_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_tick;
        logic rsp_free;
    } sts_t;

endpackage

### rtl/core/multi_channel_timeout_bank.sv
// Top level of the multi-channel timeout bank.
//
//   channel | ports                  | direction | contents
//   --------+------------------------+-----------+------------------------------------
//   command | cmd_valid, cmd_stall   | in        | command, channel, period, delay
//   status  | rsp_valid, rsp_stall   | out       | was_expired, active_bits, expired_bits
//
// Start, stop and test-and-clear go through the apply and finish states to the response.
// A tick goes through the walk and finish states: one shared decrementer walks the channels
// through a one-read one-write count memory, one channel per cycle, reads overlapped.
// Reset clears all active and expired bits; counts and periods need no reset.
// A new transaction is taken while a finished response still waits, and a
// stalled response only holds the next response back.
module multi_channel_timeout_bank #(
    parameter int CHANNELS = mctb_pkg::CHANNELS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  mctb_pkg::cmd_t  cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output mctb_pkg::rsp_t  rsp
);

    mctb_pkg::ctl_t ctl;
    mctb_pkg::sts_t sts;

    mctb_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    mctb_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

### rtl/core/mctb_ctrl.sv
// Sequencer for the timeout bank: accepts transactions and walks channels on a tick.
module mctb_ctrl #(
    parameter int CHANNELS = mctb_pkg::CHANNELS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  mctb_pkg::sts_t   sts,
    output mctb_pkg::ctl_t   ctl
);

    localparam int PTR_W = $clog2(CHANNELS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_WALK,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             stall_reg, stall_next;

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        ctl         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load   = 1'b1;
                    ptr_next   = '0;
                    state_next = sts.is_tick ? S_WALK : S_APPLY;
                end
            end
            S_APPLY:
            begin
                ctl.apply  = 1'b1;
                state_next = S_FINISH;
            end
            S_WALK:
            begin
                // Read of channel ptr overlaps the update of channel ptr-1.
                ctl.rd_en   = (ptr_reg < PTR_W'(CHANNELS));
                ctl.rd_idx  = mctb_pkg::CHAN_W'(ptr_reg);
                ctl.upd_en  = (ptr_reg != '0);
                ctl.upd_idx = mctb_pkg::CHAN_W'(ptr_reg - 1'b1);
                ptr_next    = ptr_reg + 1'b1;
                if (ptr_reg == PTR_W'(CHANNELS))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.rsp_free)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        stall_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg   <= '0;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            stall_reg <= stall_next;
        end
    end

    assign cmd_stall = stall_reg;

endmodule

### rtl/core/mctb_datapath.sv
// Count and period memories, flag registers, shared decrementer and response register.
module mctb_datapath #(
    parameter int CHANNELS = mctb_pkg::CHANNELS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mctb_pkg::cmd_t   cmd,
    input  mctb_pkg::ctl_t   ctl,
    output mctb_pkg::sts_t   sts,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output mctb_pkg::rsp_t   rsp
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    mctb_pkg::cmd_t                 item_reg;
    logic [mctb_pkg::COUNT_W-1:0]   count_mem  [CHANNELS];
    logic [mctb_pkg::COUNT_W-1:0]   period_mem [CHANNELS];
    logic [mctb_pkg::COUNT_W-1:0]   count_rd_reg, period_rd_reg;

    logic [mctb_pkg::FLAGS_W-1:0]   active_reg, active_next;
    logic [mctb_pkg::FLAGS_W-1:0]   expired_reg, expired_next;
    logic                           was_reg, was_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    mctb_pkg::rsp_t                 rsp_reg;

    logic                           item_ok;
    logic [mctb_pkg::FLAGS_W-1:0]   item_mask, upd_mask;
    logic [mctb_pkg::COUNT_W-1:0]   count_dec;
    logic                           upd_live;
    logic                           count_we, period_we;
    logic [IDX_W-1:0]               wr_idx;
    logic [mctb_pkg::COUNT_W-1:0]   count_wd;

    assign item_ok   = ({1'b0, item_reg.channel} < (mctb_pkg::CHAN_W + 1)'(CHANNELS));
    assign item_mask = mctb_pkg::FLAGS_W'(1) << item_reg.channel;
    assign upd_mask  = mctb_pkg::FLAGS_W'(1) << ctl.upd_idx;
    assign count_dec = count_rd_reg - 1'b1;
    assign upd_live  = ctl.upd_en && ((active_reg & upd_mask) != '0);

    always_comb
    begin
        active_next  = active_reg;
        expired_next = expired_reg;
        was_next     = was_reg;
        count_we     = 1'b0;
        period_we    = 1'b0;
        wr_idx       = item_reg.channel[IDX_W-1:0];
        count_wd     = item_reg.first_delay;

        if (ctl.load)
        begin
            was_next = 1'b0;
        end

        if (ctl.apply && item_ok)
        begin
            case (item_reg.command)
                mctb_pkg::CMD_START:
                begin
                    count_we     = 1'b1;
                    period_we    = 1'b1;
                    active_next  = active_reg | item_mask;
                    expired_next = expired_reg & ~item_mask;
                end
                mctb_pkg::CMD_STOP:
                begin
                    active_next = active_reg & ~item_mask;
                end
                mctb_pkg::CMD_TEST:
                begin
                    was_next     = ((expired_reg & item_mask) != '0);
                    expired_next = expired_reg & ~item_mask;
                end
                default:
                begin
                    was_next = 1'b0;
                end
            endcase
        end

        if (upd_live)
        begin
            count_we = 1'b1;
            wr_idx   = ctl.upd_idx[IDX_W-1:0];
            if (count_dec == '0)
            begin
                expired_next = expired_reg | upd_mask;
                count_wd     = period_rd_reg;
                // A zero period makes the timeout single shot.
                if (period_rd_reg == '0)
                begin
                    active_next = active_reg & ~upd_mask;
                end
            end
            else
            begin
                count_wd = count_dec;
            end
        end

        if (ctl.capture)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            item_reg <= cmd;
        end
        if (count_we)
        begin
            count_mem[wr_idx] <= count_wd;
        end
        if (period_we)
        begin
            period_mem[wr_idx] <= item_reg.reload_period;
        end
        if (ctl.rd_en)
        begin
            count_rd_reg  <= count_mem[ctl.rd_idx[IDX_W-1:0]];
            period_rd_reg <= period_mem[ctl.rd_idx[IDX_W-1:0]];
        end
        if (ctl.capture)
        begin
            rsp_reg.was_expired  <= was_reg;
            rsp_reg.active_bits  <= active_reg;
            rsp_reg.expired_bits <= expired_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            expired_reg   <= '0;
            was_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            expired_reg   <= expired_next;
            was_reg       <= was_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign sts.is_tick  = (cmd.command == mctb_pkg::CMD_TICK);
    assign sts.rsp_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;

endmodule

### rtl/core/mctb_checker.sv
// Port-level checks for the timeout bank, bound to the top level.
module mctb_checker #(
    parameter int CHANNELS = mctb_pkg::CHANNELS_DEFAULT
) (
    input logic            clk,
    input logic            rst_n,
    input logic            cmd_valid,
    input logic            cmd_stall,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input mctb_pkg::rsp_t  rsp
);

    // A stalled response stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped while stalled");

    // A stalled response does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
        else $error("response changed while stalled");

    // The block goes busy after it takes a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("second transaction taken before the first finished");

    // A new response only follows a transaction in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd_stall))
        else $error("response without a transaction");

    // Channels beyond the bank never show as active or expired.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (((rsp.active_bits | rsp.expired_bits) >> CHANNELS) == '0))
        else $error("flag set for a channel outside the bank");

endmodule

bind multi_channel_timeout_bank mctb_checker #(
    .CHANNELS (CHANNELS)
) u_mctb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

### tb/sv/tb.sv
// Self-checking testbench for the multi-channel timeout bank.
`timescale 1ns / 1ps

module tb;

    localparam int CHANNELS = mctb_pkg::CHANNELS_DEFAULT;
    localparam int COUNT_W = mctb_pkg::COUNT_W;
    localparam int FLAGS_W = mctb_pkg::FLAGS_W;
    localparam int CHAN_W = mctb_pkg::CHAN_W;
    localparam int CMD_W = $bits(mctb_pkg::cmd_t);
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int TICK_LATENCY = CHANNELS + 3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    mctb_pkg::cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    mctb_pkg::rsp_t rsp;

    multi_channel_timeout_bank #(
        .CHANNELS(CHANNELS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow copy of the timeout bank.
    logic [COUNT_W-1:0] shadow_count [mctb_pkg::MAX_CHANNELS];
    logic [COUNT_W-1:0] shadow_period [mctb_pkg::MAX_CHANNELS];
    logic [FLAGS_W-1:0] shadow_active = '0;
    logic [FLAGS_W-1:0] shadow_expired = '0;

    mctb_pkg::rsp_t pending_status [$];

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned watchdog_count = 0;
    int unsigned statuses_checked = 0;
    int unsigned ticks_sent = 0;
    int unsigned starts_sent = 0;
    int unsigned stops_sent = 0;
    int unsigned tests_sent = 0;
    int unsigned expiries_cleared = 0;

    function automatic mctb_pkg::rsp_t predict_status(mctb_pkg::cmd_t c);
        mctb_pkg::rsp_t r;
        int ch;
        logic hit;
        r = '0;
        hit = (int'(c.channel) < CHANNELS);
        case (mctb_pkg::cmd_code_t'(c.command))
            mctb_pkg::CMD_TICK:
            begin
                for (ch = 0; ch < CHANNELS; ch++)
                begin
                    if (shadow_active[ch])
                    begin
                        shadow_count[ch] = shadow_count[ch] - 1'b1;
                        if (shadow_count[ch] == '0)
                        begin
                            shadow_expired[ch] = 1'b1;
                            if (shadow_period[ch] != '0)
                                shadow_count[ch] = shadow_period[ch];
                            else
                                shadow_active[ch] = 1'b0;
                        end
                    end
                end
            end
            mctb_pkg::CMD_START:
            begin
                if (hit)
                begin
                    shadow_count[c.channel] = c.first_delay;
                    shadow_period[c.channel] = c.reload_period;
                    shadow_active[c.channel] = 1'b1;
                    shadow_expired[c.channel] = 1'b0;
                end
            end
            mctb_pkg::CMD_STOP:
            begin
                if (hit)
                    shadow_active[c.channel] = 1'b0;
            end
            default:
            begin
                if (hit && shadow_expired[c.channel])
                begin
                    r.was_expired = 1'b1;
                    shadow_expired[c.channel] = 1'b0;
                end
            end
        endcase
        r.active_bits = shadow_active;
        r.expired_bits = shadow_expired;
        return r;
    endfunction

    function automatic mctb_pkg::cmd_t make_cmd(mctb_pkg::cmd_code_t op, int ch,
                                                logic [COUNT_W-1:0] period,
                                                logic [COUNT_W-1:0] delay);
        mctb_pkg::cmd_t c;
        c.command = op;
        c.channel = CHAN_W'(ch);
        c.reload_period = period;
        c.first_delay = delay;
        return c;
    endfunction

    // Mostly short counts so that expiries are frequent, now and then the full range.
    function automatic logic [COUNT_W-1:0] pick_count(int small_max);
        int r;
        r = $urandom_range(99);
        if (r < 84)
            return COUNT_W'($urandom_range(small_max));
        else if (r < 94)
            return COUNT_W'($urandom);
        else if (r < 97)
            return '1;
        else
            return '0;
    endfunction

    // Sends one transaction, with random sender gaps before it.
    task automatic send_cmd(mctb_pkg::cmd_t c);
        mctb_pkg::rsp_t expected;
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            cmd <= mctb_pkg::cmd_t'(CMD_W'({$urandom, $urandom}));
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (cmd_stall);
        expected = predict_status(c);
        pending_status.push_back(expected);
        case (mctb_pkg::cmd_code_t'(c.command))
            mctb_pkg::CMD_TICK:  ticks_sent++;
            mctb_pkg::CMD_START: starts_sent++;
            mctb_pkg::CMD_STOP:  stops_sent++;
            default:             tests_sent++;
        endcase
        if (expected.was_expired)
            expiries_cleared++;
    endtask

    task automatic send_tick();
        send_cmd(make_cmd(mctb_pkg::CMD_TICK, $urandom_range(7),
                          COUNT_W'($urandom), COUNT_W'($urandom)));
    endtask

    // Holds the sender off until the bank has answered everything.
    task automatic drain_status();
        @(negedge clk);
        cmd_valid <= 1'b0;
        wait (pending_status.size() == 0);
    endtask

    task automatic report_mismatch(string what, int unsigned exp_val, int unsigned got_val);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s at %0t: expected %0h, got %0h",
                     what, $realtime, exp_val, got_val);
    endtask

    always @(negedge clk)
        rsp_stall <= ($urandom_range(99) < rsp_stall_pct);

    // Response checker and watchdog.
    always @(posedge clk)
    begin
        mctb_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_status.size() == 0)
            begin
                report_mismatch("unexpected response", 0, 32'(rsp));
            end
            else
            begin
                want = pending_status.pop_front();
                statuses_checked++;
                if (rsp.was_expired !== want.was_expired)
                    report_mismatch("was_expired", 32'(want.was_expired),
                                    32'(rsp.was_expired));
                if (rsp.active_bits !== want.active_bits)
                    report_mismatch("active_bits", 32'(want.active_bits),
                                    32'(rsp.active_bits));
                if (rsp.expired_bits !== want.expired_bits)
                    report_mismatch("expired_bits", 32'(want.expired_bits),
                                    32'(rsp.expired_bits));
            end
        end
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            watchdog_count <= 0;
        else if (watchdog_count + 1 >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: FAIL");
            $finish;
        end
        else
            watchdog_count <= watchdog_count + 1;
    end

    // A single-shot timeout expires once, deactivates, and test-and-clear reads it once.
    task automatic test_single_shot();
        send_cmd(make_cmd(mctb_pkg::CMD_TEST, 0, 16'h0000, 16'h0000));
        send_cmd(make_cmd(mctb_pkg::CMD_START, 0, 16'h0000, 16'h0001));
        send_tick();
        send_cmd(make_cmd(mctb_pkg::CMD_TEST, 0, 16'hFFFF, 16'hFFFF));
        send_cmd(make_cmd(mctb_pkg::CMD_TEST, 0, 16'h0000, 16'h0000));
    endtask

    // A periodic timeout reloads; stopping an idle channel keeps its expired bit.
    task automatic test_periodic();
        send_cmd(make_cmd(mctb_pkg::CMD_START, 7, 16'h0001, 16'h0002));
        send_tick();
        send_tick();
        send_tick();
        send_cmd(make_cmd(mctb_pkg::CMD_STOP, 7, 16'hFFFF, 16'hFFFF));
        send_cmd(make_cmd(mctb_pkg::CMD_STOP, 7, 16'h0000, 16'h0000));
        send_cmd(make_cmd(mctb_pkg::CMD_TEST, 7, 16'h0000, 16'h0000));
    endtask

    // Restarting a channel with a pending expiry clears the expired bit.
    task automatic test_restart();
        send_cmd(make_cmd(mctb_pkg::CMD_START, 3, 16'h0003, 16'h0001));
        send_tick();
        send_cmd(make_cmd(mctb_pkg::CMD_START, 3, 16'hFFFF, 16'hFFFF));
        send_tick();
        send_cmd(make_cmd(mctb_pkg::CMD_TEST, 3, 16'h0000, 16'h0000));
        send_cmd(make_cmd(mctb_pkg::CMD_STOP, 3, 16'h0000, 16'h0000));
    endtask

    // A zero first delay wraps rather than expiring; extreme values on other channels.
    task automatic test_zero_delay();
        send_cmd(make_cmd(mctb_pkg::CMD_START, 5, 16'h0000, 16'h0000));
        send_cmd(make_cmd(mctb_pkg::CMD_START, 4, 16'hFFFF, 16'hFFFF));
        send_cmd(make_cmd(mctb_pkg::CMD_START, 2, 16'h5555, 16'hAAAA));
        send_tick();
        send_cmd(make_cmd(mctb_pkg::CMD_TEST, 5, 16'h0000, 16'h0000));
        send_cmd(make_cmd(mctb_pkg::CMD_STOP, 5, 16'h0000, 16'h0000));
        send_cmd(make_cmd(mctb_pkg::CMD_STOP, 4, 16'h0000, 16'h0000));
        send_cmd(make_cmd(mctb_pkg::CMD_STOP, 2, 16'h0000, 16'h0000));
    endtask

    // Mostly start / tick / test sequences with random content, plus random noise.
    task automatic test_random(int unsigned items, int send_pct, int stall_pct);
        int unsigned sent;
        int unsigned next_pause;
        int ch;
        int steps;
        int r;
        send_idle_pct = send_pct;
        rsp_stall_pct = stall_pct;
        sent = 0;
        next_pause = 150;
        while (sent < items)
        begin
            if ($urandom_range(99) < 75)
            begin
                ch = $urandom_range(CHANNELS - 1);
                send_cmd(make_cmd(mctb_pkg::CMD_START, ch, pick_count(4), pick_count(6)));
                steps = $urandom_range(1, 8);
                sent += steps + 2;
                repeat (steps)
                begin
                    r = $urandom_range(99);
                    if (r < 65)
                        send_tick();
                    else if (r < 88)
                        send_cmd(make_cmd(mctb_pkg::CMD_TEST, $urandom_range(CHANNELS - 1),
                                          COUNT_W'($urandom), COUNT_W'($urandom)));
                    else
                        send_cmd(make_cmd(mctb_pkg::CMD_STOP, $urandom_range(CHANNELS - 1),
                                          COUNT_W'($urandom), COUNT_W'($urandom)));
                end
                send_cmd(make_cmd(mctb_pkg::CMD_TEST, ch,
                                  COUNT_W'($urandom), COUNT_W'($urandom)));
            end
            else
            begin
                send_cmd(make_cmd(mctb_pkg::cmd_code_t'($urandom_range(3)),
                                  $urandom_range(7), pick_count(8), pick_count(8)));
                sent++;
            end
            if (sent >= next_pause)
            begin
                drain_status();
                next_pause += 150 + $urandom_range(100);
            end
        end
        drain_status();
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_single_shot();
        test_periodic();
        test_restart();
        test_zero_delay();
        drain_status();

        test_random(450, 0, 0);
        test_random(450, 47, 0);
        test_random(450, 0, 47);
        test_random(450, 32, 32);

        @(negedge clk);
        cmd_valid <= 1'b0;
        rsp_stall_pct = 0;
        wait (pending_status.size() == 0);
        repeat (2 * TICK_LATENCY) @(posedge clk);

        $display("covered %0d ticks, %0d starts, %0d stops, %0d test-and-clears",
                 ticks_sent, starts_sent, stops_sent, tests_sent);
        $display("checked %0d responses, %0d reported an expiry, %0d mismatches",
                 statuses_checked, expiries_cleared, mismatches);
        if (mismatches == 0 && pending_status.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

### files.f
rtl/core/mctb_pkg.sv
rtl/core/mctb_ctrl.sv
rtl/core/mctb_datapath.sv
rtl/core/multi_channel_timeout_bank.sv
rtl/core/mctb_checker.sv
tb/sv/tb.sv
